// ===== sv/slot_bitmap_run_allocator_defines.svh =====
// Assertion macros shared by the slot bitmap run allocator checkers.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SLOT_BITMAP_RUN_ALLOCATOR_DEFINES_SVH
`define SLOT_BITMAP_RUN_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SBRA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SBRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== sv/sbra_pkg.sv =====
// Package for the slot bitmap run allocator: item types, request codes,
// map constants and run pattern helpers. Depends on nothing.
package sbra_pkg;

    // Geometry of the occupancy map. Slot s lives in bit MAP_W-1-s.
    localparam int SLOTS  = 64;
    localparam int MAP_W  = 64;
    localparam int POS_W  = 6;
    localparam int BLK_W  = 16;
    localparam int LINK_W = 22;
    localparam int LEN_W  = 4;

    // Search window limits: the last start slot, and the limit that the sum start+len may not exceed.
    localparam int LAST_START = SLOTS - 4;
    localparam int END_LIMIT  = SLOTS - 1;

    localparam logic [MAP_W-1:0] ALL_ONES   = {MAP_W{1'b1}};
    localparam logic [MAP_W-1:0] VALID_MASK = ~(ALL_ONES >> SLOTS);
    localparam logic [MAP_W-1:0] LINK_BIT   = MAP_W'(1) << (MAP_W - SLOTS);
    localparam logic [MAP_W-1:0] RESET_MAP  = (ALL_ONES << (MAP_W - 2)) & VALID_MASK;

    // Request codes.
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_LINK  = 2'd2;
    localparam logic [1:0] REQ_LOAD  = 2'd3;

    // Size class codes.
    localparam logic [1:0] CLS_TWO    = 2'd0;
    localparam logic [1:0] CLS_NINE   = 2'd1;
    localparam logic [1:0] CLS_TWELVE = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [1:0]        size_class;
        logic [POS_W-1:0]  position;
        logic [BLK_W-1:0]  block_number;
        logic [MAP_W-1:0]  map_value;
    } cmd_t;

    typedef struct packed {
        logic              granted;
        logic [POS_W-1:0]  slot_position;
        logic [MAP_W-1:0]  occupancy;
        logic [LINK_W-1:0] link_value;
    } rsp_t;

    // Run length of a size class; the unused class has length zero.
    function automatic logic [LEN_W-1:0] run_length(input logic [1:0] cls);
        logic [LEN_W-1:0] len;
        case (cls)
            CLS_TWO:    len = LEN_W'(2);
            CLS_NINE:   len = LEN_W'(9);
            CLS_TWELVE: len = LEN_W'(12);
            default:    len = '0;
        endcase
        return len;
    endfunction

    // Run mask of a size class placed at slot 0.
    function automatic logic [MAP_W-1:0] run_pattern(input logic [1:0] cls);
        logic [MAP_W-1:0] pat;
        case (cls)
            CLS_TWO:    pat = ~(ALL_ONES >> 2);
            CLS_NINE:   pat = ~(ALL_ONES >> 9);
            CLS_TWELVE: pat = ~(ALL_ONES >> 12);
            default:    pat = '0;
        endcase
        return pat;
    endfunction

endpackage

// ===== sv/sbra_run_unit.sv =====
// Shared run unit: shifts the run pattern of a size class to a start slot
// and tests it against the map. Depends on sbra_pkg.
module sbra_run_unit (
    input  logic [sbra_pkg::MAP_W-1:0] map,
    input  logic [1:0]                 size_class,
    input  logic [sbra_pkg::POS_W-1:0] offset,
    output logic [sbra_pkg::MAP_W-1:0] mask,
    output logic                       clear
);
    import sbra_pkg::*;

    // Slots that grow in number sit at lower bits, so a right shift moves the run.
    assign mask  = run_pattern(size_class) >> offset;
    assign clear = ((map & mask) == '0);

endmodule

// ===== sv/slot_bitmap_run_allocator.sv =====
// Top level of the slot bitmap run allocator: command handshake, scan
// sequencer, map and link registers. Depends on sbra_pkg and sbra_run_unit.
//
// A free, link or load item, and an allocate item of the unused size class,
// is done in the cycle it is accepted: its result strobes on done in the next
// cycle and busy never rises. An allocate item tests one start slot per cycle
// in the shared run unit, from slot 0 upward, and holds busy high while it
// scans. When a run is found its result follows the last start tried; the
// number of starts tried is at most SLOTS-3 for two-slot runs, SLOTS-9 for nine
// and SLOTS-12 for twelve. When no run is found the scan goes on until it sees
// the end of the window, so the longest item is a refused two-slot allocation.
// A result is marked valid on rsp by done, which is high for a single cycle;
// the receiver cannot stall it, so it must capture it in that cycle.
module slot_bitmap_run_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  sbra_pkg::cmd_t cmd,
    output logic           done,
    output sbra_pkg::rsp_t rsp
);
    import sbra_pkg::*;

    state_t              state_reg, state_next;
    logic [MAP_W-1:0]    map_reg, map_next;
    logic [LINK_W-1:0]   link_reg, link_next;
    logic [POS_W-1:0]    idx_reg, idx_next;
    logic [1:0]          cls_reg, cls_next;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;

    logic                accept;
    logic                scanning;
    logic [1:0]          unit_cls;
    logic [POS_W-1:0]    unit_offset;
    logic [MAP_W-1:0]    unit_mask;
    logic                unit_clear;
    logic [LEN_W-1:0]    cmd_len;
    logic [LEN_W-1:0]    scan_len;
    logic                window_end;
    logic                finish;
    logic                grant;
    logic [POS_W-1:0]    found;

    // Control outputs of the sequencer.
    always_comb
    begin
        busy     = (state_reg == ST_SCAN);
        scanning = (state_reg == ST_SCAN);
        accept   = start && (state_reg == ST_IDLE);
    end

    // The shared unit sees the scan index while scanning, else the new item.
    assign unit_cls    = scanning ? cls_reg : cmd.size_class;
    assign unit_offset = scanning ? idx_reg : cmd.position;

    sbra_run_unit u_run (
        .map        (map_reg),
        .size_class (unit_cls),
        .offset     (unit_offset),
        .mask       (unit_mask),
        .clear      (unit_clear)
    );

    assign cmd_len  = run_length(cmd.size_class);
    assign scan_len = run_length(cls_reg);

    // The scan ends when the start passes the last start slot or the run would
    // reach the link slot.
    assign window_end = (idx_reg > POS_W'(LAST_START))
        || ((POS_W + 1)'(idx_reg) + (POS_W + 1)'(scan_len) > (POS_W + 1)'(END_LIMIT));

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.req_type == REQ_ALLOC) && (cmd_len != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (window_end || unit_clear)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath: map, link, scan index and the result register.
    always_comb
    begin
        map_next  = map_reg;
        link_next = link_reg;
        idx_next  = idx_reg;
        cls_next  = cls_reg;
        done_next = 1'b0;
        rsp_next  = rsp_reg;
        finish    = 1'b0;
        grant     = 1'b0;
        found     = '0;

        if (scanning)
        begin
            if (window_end)
            begin
                finish = 1'b1;
            end
            else if (unit_clear)
            begin
                map_next = (map_reg | unit_mask) & VALID_MASK;
                finish   = 1'b1;
                grant    = 1'b1;
                found    = idx_reg;
            end
            else
            begin
                idx_next = idx_reg + POS_W'(1);
            end
        end
        else if (accept)
        begin
            finish = 1'b1;
            case (cmd.req_type)
                REQ_ALLOC:
                begin
                    if (cmd_len != '0)
                    begin
                        finish   = 1'b0;
                        idx_next = '0;
                        cls_next = cmd.size_class;
                    end
                end
                REQ_FREE:
                begin
                    if ((cmd_len != '0)
                        && ((POS_W + 1)'(cmd.position) < (POS_W + 1)'(SLOTS)))
                    begin
                        map_next = map_reg & ~unit_mask & VALID_MASK;
                    end
                end
                REQ_LINK:
                begin
                    link_next = {cmd.block_number, 6'b0};
                    map_next  = (map_reg | LINK_BIT) & VALID_MASK;
                end
                REQ_LOAD:
                begin
                    map_next = cmd.map_value & VALID_MASK;
                end
                default:
                begin
                end
            endcase
        end

        // A finished item loads the result register for one strobe cycle.
        if (finish)
        begin
            done_next              = 1'b1;
            rsp_next.granted       = grant;
            rsp_next.slot_position = found;
            rsp_next.occupancy     = map_next;
            rsp_next.link_value    = link_next;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            map_reg   <= RESET_MAP;
            link_reg  <= '0;
            idx_reg   <= '0;
            cls_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            map_reg   <= map_next;
            link_reg  <= link_next;
            idx_reg   <= idx_next;
            cls_reg   <= cls_next;
            done_reg  <= done_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== sv/sbra_checker.sv =====
// Port-level checker for the slot bitmap run allocator, bound to the top level.
// Depends on sbra_pkg and slot_bitmap_run_allocator_defines.svh.
`include "slot_bitmap_run_allocator_defines.svh"

module sbra_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input sbra_pkg::cmd_t cmd,
    input logic           done,
    input sbra_pkg::rsp_t rsp
);
    import sbra_pkg::*;

    logic quick_accept;
    logic grant_sane;

    // An accepted item that is not an allocation.
    assign quick_accept = start && !busy && (cmd.req_type != REQ_ALLOC);

    // The granted start slot is used in the returned map and lies in the window.
    assign grant_sane = rsp.occupancy[(MAP_W - 1) - int'(rsp.slot_position)]
        && (rsp.slot_position <= POS_W'(LAST_START));

    // A result without a grant, such as a refused allocation, reports slot zero.
    `SBRA_ASSERT_IMPL(a_no_grant_pos, clk, rst_n, done && !rsp.granted, rsp.slot_position == '0)

    // A granted run starts at a slot that the returned map shows as used.
    `SBRA_ASSERT_IMPL(a_grant_used, clk, rst_n, done && rsp.granted, grant_sane)

    // Items other than allocations finish in the cycle after acceptance.
    `SBRA_ASSERT_NEXT(a_quick_done, clk, rst_n, quick_accept, done && !rsp.granted)

    // No result strobes while a scan is running.
    `SBRA_ASSERT_IMPL(a_busy_quiet, clk, rst_n, busy, !done)

endmodule

bind slot_bitmap_run_allocator sbra_checker u_sbra_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
);
